// File: rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// shared types and constants for the scrolled tile map row renderer
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int TILE_PIXELS   = 16;
    localparam int TILE_SHIFT    = $clog2(TILE_PIXELS);
    localparam int SHEET_COLUMNS = 16;
    localparam int TILE_ID_MAX   = 1023;

    localparam int TILE_W   = 10;
    localparam int COL_W    = 8;
    localparam int ROW_W    = 6;
    localparam int LAYER_W  = 2;
    localparam int SCROLL_W = 12;
    localparam int SCRW_W   = 6;
    localparam int POS_W    = 12;
    localparam int DX_W     = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_RENDER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 4'd1;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } walk_state_t;

    typedef struct packed {
        logic                  vld;
        logic                  in_range;
        logic [SCRW_W-1:0]     x;
        logic                  last;
        logic [TILE_SHIFT-1:0] fine;
        logic [POS_W-1:0]      dest_y;
    } col_req_t;

    typedef struct packed {
        logic                   visible;
        logic [TILE_W-1:0]      tile_out;
        logic signed [DX_W-1:0] dest_x;
        logic [POS_W-1:0]       dest_y;
        logic [POS_W-1:0]       src_x;
        logic [POS_W-1:0]       src_y;
        logic                   last;
    } result_t;

endpackage

// File: rtl/tsr_if.sv
// ----------------------------------------------------------------------------
// tsr channels
// valid/ready channels for items, results and configuration writes
// ----------------------------------------------------------------------------
interface tsr_item_if import tsr_pkg::*;;
    logic                valid;
    logic                ready;
    logic                action;
    logic [LAYER_W-1:0]  layer;
    logic [COL_W-1:0]    map_col;
    logic [ROW_W-1:0]    map_row;
    logic [TILE_W-1:0]   tile_value;
    logic [SCROLL_W-1:0] scroll_x;

    modport source (output valid, action, layer, map_col, map_row, tile_value, scroll_x,
                    input ready);
    modport sink   (input valid, action, layer, map_col, map_row, tile_value, scroll_x,
                    output ready);
endinterface

interface tsr_result_if import tsr_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   visible;
    logic [TILE_W-1:0]      tile_out;
    logic signed [DX_W-1:0] dest_x;
    logic [POS_W-1:0]       dest_y;
    logic [POS_W-1:0]       src_x;
    logic [POS_W-1:0]       src_y;
    logic                   last;

    modport source (output valid, visible, tile_out, dest_x, dest_y, src_x, src_y, last,
                    input ready);
    modport sink   (input valid, visible, tile_out, dest_x, dest_y, src_x, src_y, last,
                    output ready);
endinterface

interface tsr_cfg_if import tsr_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/tsr_tile_ram.sv
// ----------------------------------------------------------------------------
// tsr_tile_ram
// tile id store, one write port and one registered read port
// ----------------------------------------------------------------------------
module tsr_tile_ram
    import tsr_pkg::*;
#(
    parameter int DEPTH = 65536,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [TILE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [TILE_W-1:0] rd_data
);

    logic [TILE_W-1:0] mem [DEPTH];
    logic [TILE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/tsr_walker.sv
// ----------------------------------------------------------------------------
// tsr_walker
// takes items and config beats, writes tiles, walks the columns of a row
// ----------------------------------------------------------------------------
module tsr_walker
    import tsr_pkg::*;
#(
    parameter int MAP_MAX_WIDTH  = 256,
    parameter int MAP_MAX_HEIGHT = 64,
    parameter int LAYER_COUNT    = 4,
    localparam int LAYER_SIZE    = MAP_MAX_WIDTH * MAP_MAX_HEIGHT,
    localparam int DEPTH         = LAYER_SIZE * LAYER_COUNT,
    localparam int AW            = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    tsr_item_if.sink          item,
    tsr_cfg_if.sink           cfg,
    input  logic              issue_ok,
    output col_req_t          col_req,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [TILE_W-1:0] wr_data
);

    localparam int START_W = SCROLL_W - TILE_SHIFT;
    localparam int CPOS_W  = COL_W + 1;

    walk_state_t           state_reg, state_next;
    logic [COL_W-1:0]      map_width_reg;
    logic [SCRW_W-1:0]     scr_w_reg;
    logic [AW-1:0]         base_reg;
    logic [START_W-1:0]    start_reg;
    logic [TILE_SHIFT-1:0] fine_reg;
    logic [POS_W-1:0]      dest_y_reg;
    logic                  span_ok_reg;
    logic [SCRW_W-1:0]     x_reg, x_next;
    logic                  wr_en_reg;
    logic [AW-1:0]         wr_addr_reg;
    logic [TILE_W-1:0]     wr_data_reg;

    logic [COL_W-1:0]          eff_w;
    logic                      layer_ok;
    logic                      row_ok;
    logic [COL_W+ROW_W-1:0]    row_prod;
    logic [AW-1:0]             row_base;
    logic                      accept;
    logic                      issue;
    logic                      last_col;
    logic [CPOS_W-1:0]         col;
    logic                      in_range;
    logic                      wr_ok;
    logic [TILE_W-1:0]         value_clamped;

    assign eff_w    = (32'(map_width_reg) > MAP_MAX_WIDTH) ? COL_W'(MAP_MAX_WIDTH)
                                                            : map_width_reg;
    assign layer_ok = 32'(item.layer) < LAYER_COUNT;
    assign row_ok   = 32'(item.map_row) < MAP_MAX_HEIGHT;
    assign row_prod = (COL_W+ROW_W)'(item.map_row) * (COL_W+ROW_W)'(eff_w);
    assign row_base = AW'(row_prod) + AW'(item.layer) * AW'(LAYER_SIZE);

    assign wr_ok         = layer_ok && row_ok && (item.map_col < eff_w);
    assign value_clamped = (32'(item.tile_value) > TILE_ID_MAX) ? TILE_W'(TILE_ID_MAX)
                                                                : item.tile_value;

    assign col      = CPOS_W'(start_reg) + CPOS_W'(x_reg);
    assign in_range = span_ok_reg && (col < CPOS_W'(eff_w));
    assign last_col = (x_reg == scr_w_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item.ready = 1'b0;
        issue      = 1'b0;
        x_next     = x_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                x_next     = '0;
                if (item.valid && item.action == ACT_RENDER)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                issue = issue_ok;
                if (issue_ok)
                begin
                    x_next = x_reg + 1'b1;
                    if (last_col)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    assign accept = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg <= COL_W'(255);
            scr_w_reg     <= SCRW_W'(20);
            x_reg         <= '0;
            wr_en_reg     <= 1'b0;
        end
        else
        begin
            x_reg     <= x_next;
            wr_en_reg <= accept && item.action == ACT_WRITE && wr_ok;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_MAP_WIDTH:    map_width_reg <= cfg.data;
                    CFG_SCREEN_WIDTH: scr_w_reg     <= cfg.data[SCRW_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // per-item context and pending write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg    <= row_base;
            start_reg   <= item.scroll_x[SCROLL_W-1:TILE_SHIFT];
            fine_reg    <= item.scroll_x[TILE_SHIFT-1:0];
            dest_y_reg  <= POS_W'(item.map_row) << TILE_SHIFT;
            span_ok_reg <= layer_ok && row_ok;
            wr_addr_reg <= row_base + AW'(item.map_col);
            wr_data_reg <= value_clamped;
        end
    end

    assign cfg.ready = 1'b1;

    assign rd_en   = issue;
    assign rd_addr = in_range ? base_reg + AW'(col) : '0;

    assign col_req.vld      = issue;
    assign col_req.in_range = in_range;
    assign col_req.x        = x_reg;
    assign col_req.last     = last_col;
    assign col_req.fine     = fine_reg;
    assign col_req.dest_y   = dest_y_reg;

    assign wr_en   = wr_en_reg;
    assign wr_addr = wr_addr_reg;
    assign wr_data = wr_data_reg;

endmodule

// File: rtl/tsr_out_stage.sv
// ----------------------------------------------------------------------------
// tsr_out_stage
// turns read tile ids into result beats, two-entry output queue with credit
// ----------------------------------------------------------------------------
module tsr_out_stage
    import tsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  col_req_t          col_req,
    input  logic [TILE_W-1:0] rd_data,
    output logic              issue_ok,
    tsr_result_if.source      result
);

    col_req_t          col_q_reg;
    result_t           fifo_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    logic [TILE_W-1:0] id;
    logic [TILE_W-1:0] k;
    logic [15:0]       sx_full;
    logic [15:0]       sy_full;
    result_t           res;
    result_t           head;
    logic              push;
    logic              pop;
    logic [2:0]        occ;

    assign id      = col_q_reg.in_range ? rd_data : '0;
    assign k       = id - 1'b1;
    assign sx_full = 16'(k % SHEET_COLUMNS) * 16'(TILE_PIXELS);
    assign sy_full = 16'(k / SHEET_COLUMNS) * 16'(TILE_PIXELS);

    always_comb
    begin
        res.visible  = (id != '0);
        res.tile_out = id;
        res.dest_x   = $signed((DX_W'(col_q_reg.x) << TILE_SHIFT) - DX_W'(col_q_reg.fine));
        res.dest_y   = col_q_reg.dest_y;
        res.src_x    = '0;
        res.src_y    = '0;
        res.last     = col_q_reg.last;
        if (res.visible)
        begin
            res.src_x = (sx_full > 16'd4095) ? 12'hFFF : sx_full[POS_W-1:0];
            res.src_y = (sy_full > 16'd4095) ? 12'hFFF : sy_full[POS_W-1:0];
        end
    end

    assign push = col_q_reg.vld;
    assign pop  = result.valid && result.ready;

    // slots in use once in-flight reads land
    assign occ      = 3'(count_reg) + 3'(col_q_reg.vld) - 3'(pop);
    assign issue_ok = occ < 3'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_q_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            col_q_reg <= col_req;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

    assign head = fifo_reg[rd_ptr_reg];

    assign result.valid    = (count_reg != '0);
    assign result.visible  = head.visible;
    assign result.tile_out = head.tile_out;
    assign result.dest_x   = head.dest_x;
    assign result.dest_y   = head.dest_y;
    assign result.src_x    = head.src_x;
    assign result.src_y    = head.src_y;
    assign result.last     = head.last;

endmodule

// File: rtl/tilemap_scroll_row_renderer_core.sv
// ----------------------------------------------------------------------------
// tilemap_scroll_row_renderer_core
// layered tile map store with a scrolled row walker
//
//   channel  dir  beat
//   item     in   write one tile, or render one row of a layer
//   result   out  one column of a rendered row, last on the final one
//   cfg      in   map width (index 0), screen width in tiles (index 1)
//
// a write item is taken while idle; the store is written the cycle after.
// a render item is accepted, then one store read per column on the single
// read port; each tile id is registered by the store, then by the queue.
// a two-entry output queue lets columns flow at one per cycle while results
// are taken; a stalled result side holds the walk once two beats are queued or in flight.
// reset initialises control and config only; the tile store is not cleared.
// ----------------------------------------------------------------------------
module tilemap_scroll_row_renderer_core
    import tsr_pkg::*;
#(
    parameter int MAP_MAX_WIDTH  = 256,
    parameter int MAP_MAX_HEIGHT = 64,
    parameter int LAYER_COUNT    = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    tsr_item_if.sink     item,
    tsr_result_if.source result,
    tsr_cfg_if.sink      cfg
);

    localparam int DEPTH = MAP_MAX_WIDTH * MAP_MAX_HEIGHT * LAYER_COUNT;
    localparam int AW    = $clog2(DEPTH);

    col_req_t          col_req;
    logic              issue_ok;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [TILE_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [TILE_W-1:0] wr_data;

    tsr_walker #(
        .MAP_MAX_WIDTH  (MAP_MAX_WIDTH),
        .MAP_MAX_HEIGHT (MAP_MAX_HEIGHT),
        .LAYER_COUNT    (LAYER_COUNT)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg      (cfg),
        .issue_ok (issue_ok),
        .col_req  (col_req),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    tsr_tile_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tsr_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .col_req  (col_req),
        .rd_data  (rd_data),
        .issue_ok (issue_ok),
        .result   (result)
    );

endmodule

// File: rtl/tsr_checker.sv
// ----------------------------------------------------------------------------
// tsr_checker
// port-level checks on the row renderer, bound to the top level
// ----------------------------------------------------------------------------
module tsr_checker
    import tsr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              item_action,
    input logic              res_valid,
    input logic              res_ready,
    input logic              res_visible,
    input logic [TILE_W-1:0] res_tile_out,
    input logic [POS_W-1:0]  res_src_x,
    input logic [POS_W-1:0]  res_src_y,
    input logic              res_last
);

    // stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_tile_out) && $stable(res_last))
        else $error("result beat changed while stalled");

    // a render keeps the item side closed while it walks
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_action == ACT_RENDER |=> !item_ready)
        else $error("item taken during a row walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_visible == (res_tile_out != '0))
        else $error("visible flag disagrees with tile id");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_visible |-> res_src_x == '0 && res_src_y == '0)
        else $error("empty tile carries a source position");

endmodule

bind tilemap_scroll_row_renderer_core tsr_checker u_tsr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_action  (item.action),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_visible  (result.visible),
    .res_tile_out (result.tile_out),
    .res_src_x    (result.src_x),
    .res_src_y    (result.src_y),
    .res_last     (result.last)
);
